[sv/bicv_pkg.sv]
// ---------------------------------------------------------------------------
// bicv_pkg
// Types, codes and CRC-32 helpers shared by the boot image CRC verifier.
// ---------------------------------------------------------------------------
package bicv_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned INDEX_W   = 14;
	localparam int unsigned MAXB_W    = 17;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [WORD_W-1:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] MAGIC_RST = 32'hB007_C0DE;
	localparam logic [MAXB_W-1:0] MAXB_RST  = 17'h1_0000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_IMAGE_BYTES = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_OK        = 2'd0,
		VERDICT_BAD_MAGIC = 2'd1,
		VERDICT_BAD_SIZE  = 2'd2,
		VERDICT_BAD_CRC   = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		PH_DONE    = 2'd0,
		PH_SIZE    = 2'd1,
		PH_CRC     = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef struct packed {
		logic [WORD_W-1:0] expected_magic;
		logic [MAXB_W-1:0] max_image_bytes;
	} cfg_t;

	typedef struct packed {
		logic               store_valid;
		logic [INDEX_W-1:0] store_index;
		logic [WORD_W-1:0]  store_data;
		logic               verdict_valid;
		verdict_t           verdict;
		logic [WORD_W-1:0]  calc_crc;
		logic [WORD_W-1:0]  header_crc;
	} result_t;

	// One entry of the byte-wise lookup table of the reflected CRC-32.
	function automatic logic [WORD_W-1:0] crc_table(input logic [7:0] idx);
		logic [WORD_W-1:0] c;
		c = {24'h00_0000, idx};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Advance the CRC by one word, least significant byte first.
	function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] crc,
		input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] c;
		c = crc;
		for (int b = 0; b < 4; b++) begin
			c = (c >> 8) ^ crc_table(c[7:0] ^ w[8*b +: 8]);
		end
		return c;
	endfunction

endpackage

[sv/bicv_if.sv]
// ---------------------------------------------------------------------------
// bicv channel interfaces
// Valid/ready channels for image words, results and configuration writes.
// ---------------------------------------------------------------------------
interface bicv_in_if import bicv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] image_word;
	logic              first_word;

	modport source (output valid, output image_word, output first_word, input ready);
	modport sink   (input valid, input image_word, input first_word, output ready);
endinterface

interface bicv_out_if import bicv_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               store_valid;
	logic [INDEX_W-1:0] store_index;
	logic [WORD_W-1:0]  store_data;
	logic               verdict_valid;
	logic [1:0]         verdict;
	logic [WORD_W-1:0]  calc_crc;
	logic [WORD_W-1:0]  header_crc;

	modport source (output valid, output store_valid, output store_index,
		output store_data, output verdict_valid, output verdict,
		output calc_crc, output header_crc, input ready);
	modport sink   (input valid, input store_valid, input store_index,
		input store_data, input verdict_valid, input verdict,
		input calc_crc, input header_crc, output ready);
endinterface

interface bicv_cfg_if import bicv_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/bicv_cfg_regs.sv]
// ---------------------------------------------------------------------------
// bicv_cfg_regs
// Configuration registers: expected magic and largest image size.
// ---------------------------------------------------------------------------
module bicv_cfg_regs import bicv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_magic  <= MAGIC_RST;
			cfg_q.max_image_bytes <= MAXB_RST;
		end else if (wr_valid) begin
			unique case (wr_index)
				CFG_EXPECTED_MAGIC:  cfg_q.expected_magic  <= wr_data;
				CFG_MAX_IMAGE_BYTES: cfg_q.max_image_bytes <= wr_data[MAXB_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/bicv_ctrl.sv]
// ---------------------------------------------------------------------------
// bicv_ctrl
// Header checks, payload indexing, running CRC: one word per cycle on accept.
// ---------------------------------------------------------------------------
module bicv_ctrl import bicv_pkg::*; #(
	parameter int unsigned MAX_WORDS = 16384
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              accept,
	input  logic [WORD_W-1:0] image_word,
	input  logic              first_word,
	output logic              push,
	output result_t           result
);

	localparam int unsigned WL_W = $clog2(MAX_WORDS + 1);

	phase_t             phase_q, phase_d;
	logic [WORD_W-1:0]  running_crc_q;
	logic [WORD_W-1:0]  expected_crc_q;
	logic [WL_W-1:0]    words_left_q;
	logic [INDEX_W-1:0] next_index_q;

	logic [WORD_W-1:0]  crc_next;
	logic [WORD_W-1:0]  crc_final;
	logic [WL_W-1:0]    words_left_dec;
	logic               magic_bad;
	logic               size_bad;

	assign crc_next  = crc_word(running_crc_q, image_word);
	assign crc_final = crc_next ^ CRC_INIT;
	assign words_left_dec = (words_left_q == '0) ? '0 : words_left_q - 1'b1;
	assign magic_bad = image_word != cfg.expected_magic;
	assign size_bad  = (image_word == '0)
		|| (image_word > {{(WORD_W-MAXB_W){1'b0}}, cfg.max_image_bytes})
		|| (image_word[1:0] != 2'b00)
		|| ({2'b00, image_word[WORD_W-1:2]} > WORD_W'(MAX_WORDS));

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (first_word) begin
				phase_d = magic_bad ? PH_DONE : PH_SIZE;
			end else begin
				unique case (phase_q)
					PH_SIZE:    phase_d = size_bad ? PH_DONE : PH_CRC;
					PH_CRC:     phase_d = PH_PAYLOAD;
					PH_PAYLOAD: phase_d = (words_left_dec == '0) ? PH_DONE : PH_PAYLOAD;
					default:    phase_d = PH_DONE;
				endcase
			end
		end
	end

	// Result of the word being accepted.
	always_comb begin
		push   = 1'b0;
		result = '0;
		if (accept) begin
			if (first_word) begin
				if (magic_bad) begin
					push                 = 1'b1;
					result.verdict_valid = 1'b1;
					result.verdict       = VERDICT_BAD_MAGIC;
				end
			end else begin
				unique case (phase_q)
					PH_SIZE: begin
						if (size_bad) begin
							push                 = 1'b1;
							result.verdict_valid = 1'b1;
							result.verdict       = VERDICT_BAD_SIZE;
						end
					end
					PH_PAYLOAD: begin
						push               = 1'b1;
						result.store_valid = 1'b1;
						result.store_index = next_index_q;
						result.store_data  = image_word;
						if (words_left_dec == '0) begin
							result.verdict_valid = 1'b1;
							result.verdict       = (crc_final == expected_crc_q) ?
								VERDICT_OK : VERDICT_BAD_CRC;
							result.calc_crc      = crc_final;
							result.header_crc    = expected_crc_q;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_DONE;
			running_crc_q  <= CRC_INIT;
			expected_crc_q <= '0;
			words_left_q   <= '0;
			next_index_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				if (first_word) begin
					running_crc_q  <= CRC_INIT;
					expected_crc_q <= '0;
					words_left_q   <= '0;
					next_index_q   <= '0;
				end else begin
					case (phase_q)
						PH_SIZE: begin
							if (!size_bad) begin
								words_left_q <= image_word[WL_W+1:2];
							end
						end
						PH_CRC: begin
							expected_crc_q <= image_word;
							running_crc_q  <= CRC_INIT;
							next_index_q   <= '0;
						end
						PH_PAYLOAD: begin
							running_crc_q <= crc_next;
							next_index_q  <= next_index_q + 1'b1;
							words_left_q  <= words_left_dec;
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule

[sv/bicv_out_stage.sv]
// ---------------------------------------------------------------------------
// bicv_out_stage
// Result register with a skid entry, so that input ready is a flop.
// ---------------------------------------------------------------------------
module bicv_out_stage import bicv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;

	// While the skid entry is full no new word is taken.
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !out_ready) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

[sv/boot_image_crc_verifier_core.sv]
// ---------------------------------------------------------------------------
// boot_image_crc_verifier_core
// Checks a streamed boot image header, unpacks the payload and verifies its CRC-32.
// ---------------------------------------------------------------------------
// Usage: image words enter on in_ch (image_word, first_word); first_word marks
// the magic word and restarts the checks at any time. The size and stored CRC
// words follow, then size/4 payload words. Each payload word leaves on out_ch
// with its word index; the result carrying the last payload word, or a failed
// header check, also carries the verdict. Header words and words arriving
// after a verdict without first_word give no result.
// Throughput is one word per cycle while in_ch.ready is high: the four-byte
// CRC update, the header compares and the index counter all sit between the
// accepted word and the result register, which drives out_ch.valid.
// If the receiver stalls, one further result is held in a skid entry and
// in_ch.ready then stays low until the receiver takes a word and the skid
// entry moves up into the result register.
// cfg_ch writes expected_magic (index 0) and max_image_bytes (index 1) and is
// always ready. Reset restores the register defaults, empties the output stage
// and leaves the block waiting for a first word.
// ---------------------------------------------------------------------------
module boot_image_crc_verifier_core import bicv_pkg::*; #(
	parameter int unsigned MAX_WORDS = 16384
) (
	input  logic      clk,
	input  logic      arst_n,
	bicv_in_if.sink   in_ch,
	bicv_out_if.source out_ch,
	bicv_cfg_if.sink  cfg_ch
);

	cfg_t    cfg;
	logic    accept;
	logic    push;
	logic    space;
	result_t push_data;
	result_t out_data;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = space;
	assign accept       = in_ch.valid && space;

	bicv_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_ch.valid),
		.wr_index (cfg_ch.index),
		.wr_data  (cfg_ch.data),
		.cfg      (cfg)
	);

	bicv_ctrl #(
		.MAX_WORDS (MAX_WORDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.image_word (in_ch.image_word),
		.first_word (in_ch.first_word),
		.push       (push),
		.result     (push_data)
	);

	bicv_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (space),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_data)
	);

	assign out_ch.store_valid   = out_data.store_valid;
	assign out_ch.store_index   = out_data.store_index;
	assign out_ch.store_data    = out_data.store_data;
	assign out_ch.verdict_valid = out_data.verdict_valid;
	assign out_ch.verdict       = out_data.verdict;
	assign out_ch.calc_crc      = out_data.calc_crc;
	assign out_ch.header_crc    = out_data.header_crc;

endmodule
